// ----- design/pcpd_pkg.sv -----
// Shared types and constants for the phase-code pulse decoder.
// No dependencies; imported by every other design file.
package pcpd_pkg;

  localparam int MAX_BAUD_DEF = 16;
  localparam int SAMPLE_W     = 16;
  localparam int CFG_DATA_W   = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CODE_LEN_W   = 5;
  localparam int SIGNS_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIGNS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic shift_in;
    logic rot;
    logic div_start;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic emit;
  } sts_t;

endpackage

// ----- design/phase_code_pulse_decoder.sv -----
// Phase-code pulse decoder, top level: config registers, output register.
// A beat is taken in ST_IDLE; the window rotates through every entry in ST_ACC; the
// divider loads in ST_LOAD, forms one divider bit per cycle in ST_DIV, and ST_HOLD loads out.
// Throughput: one beat per cycle while the fill count stays below the code length; after a
// beat that yields a result, none is taken until it is loaded, later while out_ready holds it.
// Reset (rst_n, synchronous): fill count cleared, code_length 1, code_signs 0.
module phase_code_pulse_decoder import pcpd_pkg::*; #(
  parameter int MAX_BAUD = MAX_BAUD_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_main_i,
  input  logic signed [SAMPLE_W-1:0] in_main_q,
  input  logic signed [SAMPLE_W-1:0] in_back_i,
  input  logic signed [SAMPLE_W-1:0] in_back_q,
  input  logic                       in_first_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_main_i_out,
  output logic signed [SAMPLE_W-1:0] out_main_q_out,
  output logic signed [SAMPLE_W-1:0] out_back_i_out,
  output logic signed [SAMPLE_W-1:0] out_back_q_out,
  input  logic                       cfg_we,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_BAUD + 1);
  localparam int SUM_W = 17 + $clog2(MAX_BAUD);

  logic [CODE_LEN_W-1:0] code_length_r;
  logic [SIGNS_W-1:0]    code_signs_r;
  logic [LEN_W-1:0]      eff_len;
  logic                  out_valid_r;
  logic                  out_free;
  cmd_t                  cmd;
  sts_t                  sts;
  logic [SAMPLE_W-1:0]   quo_mi, quo_mq, quo_bi, quo_bq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_length_r <= CODE_LEN_W'(1);
      code_signs_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CODE_LENGTH: code_length_r <= cfg_wdata[CODE_LEN_W-1:0];
        CFG_CODE_SIGNS:  code_signs_r  <= cfg_wdata[SIGNS_W-1:0];
        default: ;
      endcase
    end
  end

  // zero length acts as one; clamp to the window depth
  always_comb begin
    if (code_length_r == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(code_length_r) > 32'(MAX_BAUD)) begin
      eff_len = LEN_W'(MAX_BAUD);
    end else begin
      eff_len = LEN_W'(code_length_r);
    end
  end

  assign out_free = !out_valid_r || out_ready;

  pcpd_ctrl #(.MAX_BAUD(MAX_BAUD), .SUM_W(SUM_W)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd)
  );

  pcpd_dp #(.MAX_BAUD(MAX_BAUD), .LEN_W(LEN_W), .SUM_W(SUM_W)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .eff_len      (eff_len),
    .code_signs   (code_signs_r),
    .main_i       (in_main_i),
    .main_q       (in_main_q),
    .back_i       (in_back_i),
    .back_q       (in_back_q),
    .first_sample (in_first_sample),
    .quo_main_i   (quo_mi),
    .quo_main_q   (quo_mq),
    .quo_back_i   (quo_bi),
    .quo_back_q   (quo_bq)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_main_i_out <= quo_mi;
      out_main_q_out <= quo_mq;
      out_back_i_out <= quo_bi;
      out_back_q_out <= quo_bq;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- design/pcpd_div.sv -----
// One lane of the restoring divider: signed dividend by unsigned length,
// truncating toward zero, low 16 bits of the quotient. Uses pcpd_pkg.
module pcpd_div import pcpd_pkg::*; #(
  parameter int SUM_W = 21,
  parameter int LEN_W = 5
) (
  input  logic                    clk,
  input  logic                    start,
  input  logic                    step,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic [LEN_W-1:0]        divisor,
  output logic [SAMPLE_W-1:0]     quotient
);

  logic [SUM_W-1:0] dq_r, dq_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic             neg_r;
  logic [LEN_W:0]   shifted;
  logic [LEN_W:0]   trial;
  logic             ge;
  logic [SUM_W-1:0] dq_neg;

  always_comb begin
    shifted = {rem_r, dq_r[SUM_W-1]};
    ge      = shifted >= {1'b0, divisor};
    trial   = shifted - {1'b0, divisor};
    rem_nxt = ge ? trial[LEN_W-1:0] : shifted[LEN_W-1:0];
    dq_nxt  = {dq_r[SUM_W-2:0], ge};
    dq_neg  = -dq_r;
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SUM_W-1];
      dq_r  <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      rem_r <= '0;
    end else if (step) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = neg_r ? dq_neg[SAMPLE_W-1:0] : dq_r[SAMPLE_W-1:0];

endmodule

// ----- design/pcpd_dp.sv -----
// Datapath: sample windows, fill count, correlation accumulators and the
// four divider lanes. Uses pcpd_pkg and pcpd_div.
module pcpd_dp import pcpd_pkg::*; #(
  parameter int MAX_BAUD = MAX_BAUD_DEF,
  parameter int LEN_W    = $clog2(MAX_BAUD + 1),
  parameter int SUM_W    = 17 + $clog2(MAX_BAUD)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  cmd_t                       cmd,
  output sts_t                       sts,
  input  logic [LEN_W-1:0]           eff_len,
  input  logic [SIGNS_W-1:0]         code_signs,
  input  logic signed [SAMPLE_W-1:0] main_i,
  input  logic signed [SAMPLE_W-1:0] main_q,
  input  logic signed [SAMPLE_W-1:0] back_i,
  input  logic signed [SAMPLE_W-1:0] back_q,
  input  logic                       first_sample,
  output logic [SAMPLE_W-1:0]        quo_main_i,
  output logic [SAMPLE_W-1:0]        quo_main_q,
  output logic [SAMPLE_W-1:0]        quo_back_i,
  output logic [SAMPLE_W-1:0]        quo_back_q
);

  localparam int IDX_W  = (LEN_W > 5) ? LEN_W : 5;
  localparam int WORD_W = 2 * SAMPLE_W;

  logic [WORD_W-1:0] win_m_r [MAX_BAUD];
  logic [WORD_W-1:0] win_b_r [MAX_BAUD];
  logic [LEN_W-1:0]  fill_r, fill_nxt;
  logic [LEN_W-1:0]  tap_r;
  logic signed [SUM_W-1:0] acc_mi_r, acc_mq_r, acc_bi_r, acc_bq_r;
  logic [IDX_W-1:0]  cidx;
  logic              neg_coef;
  logic              tap_live;

  // fill count as it stands once the incoming beat is taken
  always_comb begin
    if (first_sample) begin
      fill_nxt = LEN_W'(1);
    end else if (32'(fill_r) >= 32'(MAX_BAUD)) begin
      fill_nxt = fill_r;
    end else begin
      fill_nxt = fill_r + LEN_W'(1);
    end
    sts.emit = fill_nxt >= eff_len;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.shift_in) begin
      fill_r <= fill_nxt;
    end
  end

  // shift in on a beat; rotate toward entry 0 while correlating
  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      win_m_r[0] <= {main_q, main_i};
      win_b_r[0] <= {back_q, back_i};
      for (int k = 1; k < MAX_BAUD; k++) begin
        win_m_r[k] <= win_m_r[k-1];
        win_b_r[k] <= win_b_r[k-1];
      end
    end else if (cmd.rot) begin
      for (int k = 0; k < MAX_BAUD - 1; k++) begin
        win_m_r[k] <= win_m_r[k+1];
        win_b_r[k] <= win_b_r[k+1];
      end
      win_m_r[MAX_BAUD-1] <= win_m_r[0];
      win_b_r[MAX_BAUD-1] <= win_b_r[0];
    end
  end

  always_comb begin
    tap_live = tap_r < eff_len;
    cidx     = IDX_W'(eff_len) - IDX_W'(1) - IDX_W'(tap_r);
    neg_coef = (eff_len > LEN_W'(1)) && (32'(cidx) < 32'(SIGNS_W)) &&
               code_signs[cidx[3:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.shift_in) begin
      tap_r    <= '0;
      acc_mi_r <= '0;
      acc_mq_r <= '0;
      acc_bi_r <= '0;
      acc_bq_r <= '0;
    end else if (cmd.rot && tap_live) begin
      tap_r <= tap_r + LEN_W'(1);
      if (neg_coef) begin
        acc_mi_r <= acc_mi_r - SUM_W'($signed(win_m_r[0][SAMPLE_W-1:0]));
        acc_mq_r <= acc_mq_r - SUM_W'($signed(win_m_r[0][WORD_W-1:SAMPLE_W]));
        acc_bi_r <= acc_bi_r - SUM_W'($signed(win_b_r[0][SAMPLE_W-1:0]));
        acc_bq_r <= acc_bq_r - SUM_W'($signed(win_b_r[0][WORD_W-1:SAMPLE_W]));
      end else begin
        acc_mi_r <= acc_mi_r + SUM_W'($signed(win_m_r[0][SAMPLE_W-1:0]));
        acc_mq_r <= acc_mq_r + SUM_W'($signed(win_m_r[0][WORD_W-1:SAMPLE_W]));
        acc_bi_r <= acc_bi_r + SUM_W'($signed(win_b_r[0][SAMPLE_W-1:0]));
        acc_bq_r <= acc_bq_r + SUM_W'($signed(win_b_r[0][WORD_W-1:SAMPLE_W]));
      end
    end
  end

  pcpd_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_mi (
    .clk(clk), .start(cmd.div_start), .step(cmd.div_step),
    .dividend(acc_mi_r), .divisor(eff_len), .quotient(quo_main_i)
  );

  pcpd_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_mq (
    .clk(clk), .start(cmd.div_start), .step(cmd.div_step),
    .dividend(acc_mq_r), .divisor(eff_len), .quotient(quo_main_q)
  );

  pcpd_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_bi (
    .clk(clk), .start(cmd.div_start), .step(cmd.div_step),
    .dividend(acc_bi_r), .divisor(eff_len), .quotient(quo_back_i)
  );

  pcpd_div #(.SUM_W(SUM_W), .LEN_W(LEN_W)) u_div_bq (
    .clk(clk), .start(cmd.div_start), .step(cmd.div_step),
    .dividend(acc_bq_r), .divisor(eff_len), .quotient(quo_back_q)
  );

endmodule

// ----- design/pcpd_ctrl.sv -----
// Controller: sequences beat intake, window rotation, division and the
// hand-off to the output register. Uses pcpd_pkg.
module pcpd_ctrl import pcpd_pkg::*; #(
  parameter int MAX_BAUD = MAX_BAUD_DEF,
  parameter int SUM_W    = 17 + $clog2(MAX_BAUD)
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam int CNT_MAX = (SUM_W > MAX_BAUD) ? SUM_W : MAX_BAUD;
  localparam int CNT_W   = (CNT_MAX > 1) ? $clog2(CNT_MAX) : 1;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid && sts.emit) begin
          state_nxt = ST_ACC;
        end
      end
      ST_ACC: begin
        if (32'(cnt_r) == MAX_BAUD - 1) begin
          state_nxt = ST_LOAD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_LOAD: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (32'(cnt_r) == SUM_W - 1) begin
          state_nxt = ST_HOLD;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + CNT_W'(1);
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.shift_in = in_valid;
      end
      ST_ACC:  cmd.rot       = 1'b1;
      ST_LOAD: cmd.div_start = 1'b1;
      ST_DIV:  cmd.div_step  = 1'b1;
      ST_HOLD: cmd.load_out  = out_free;
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ----- bench/phase_code_pulse_decoder_test.sv -----
// Self-checking bench for the two-channel phase-code pulse decoder.
// A directed table, then random pulse sequences, checked against a local decode model.
// Depends on pcpd_pkg and the phase_code_pulse_decoder top level only.
module phase_code_pulse_decoder_test import pcpd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY         = 40;
  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int HOLD_CYCLES     = 400;
  localparam int ITEMS_PER_PHASE = 530;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] main_i;
    logic signed [SAMPLE_W-1:0] main_q;
    logic signed [SAMPLE_W-1:0] back_i;
    logic signed [SAMPLE_W-1:0] back_q;
  } decoded_t;

  typedef struct packed {
    logic                  wr;
    logic [CODE_LEN_W-1:0] len;
    logic [SIGNS_W-1:0]    signs;
    logic [4:0]            rep;
    logic                  first;
    decoded_t              smp;
    logic                  typed;
    decoded_t              res;
  } dir_row_t;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_main_i = '0;
  logic signed [SAMPLE_W-1:0] in_main_q = '0;
  logic signed [SAMPLE_W-1:0] in_back_i = '0;
  logic signed [SAMPLE_W-1:0] in_back_q = '0;
  logic                       in_first_sample = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_main_i_out;
  logic signed [SAMPLE_W-1:0] out_main_q_out;
  logic signed [SAMPLE_W-1:0] out_back_i_out;
  logic signed [SAMPLE_W-1:0] out_back_q_out;
  logic                       cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = CFG_CODE_LENGTH;
  logic [CFG_DATA_W-1:0]      cfg_wdata = '0;

  // decode model state
  logic signed [SAMPLE_W-1:0] main_i_win [MAX_BAUD_DEF];
  logic signed [SAMPLE_W-1:0] main_q_win [MAX_BAUD_DEF];
  logic signed [SAMPLE_W-1:0] back_i_win [MAX_BAUD_DEF];
  logic signed [SAMPLE_W-1:0] back_q_win [MAX_BAUD_DEF];
  int                         fill_cnt;
  logic [CODE_LEN_W-1:0]      code_len;
  logic [SIGNS_W-1:0]         code_signs;

  decoded_t decoded_q [$];
  dir_row_t dir_rows [$];
  decoded_t exp_beat;
  int       errors = 0;
  int       cycles = 0;
  int       tx_idle = 0;
  int       rx_idle = 0;
  bit       hold_req = 0;
  int       hold_left = 0;

  phase_code_pulse_decoder dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_main_i       (in_main_i),
    .in_main_q       (in_main_q),
    .in_back_i       (in_back_i),
    .in_back_q       (in_back_q),
    .in_first_sample (in_first_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_main_i_out  (out_main_i_out),
    .out_main_q_out  (out_main_q_out),
    .out_back_i_out  (out_back_i_out),
    .out_back_q_out  (out_back_q_out),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic decoded_t quad(input int mi, input int mq, input int bi, input int bq);
    decoded_t d;
    d.main_i = SAMPLE_W'(mi);
    d.main_q = SAMPLE_W'(mq);
    d.back_i = SAMPLE_W'(bi);
    d.back_q = SAMPLE_W'(bq);
    return d;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_word();
    logic signed [SAMPLE_W-1:0] w;
    case ($urandom_range(7))
      0: w = 16'sh8000;
      1: w = 16'sh7fff;
      2: w = SAMPLE_W'($urandom_range(16) - 8);
      default: w = SAMPLE_W'($urandom);
    endcase
    return w;
  endfunction

  // shift one sample in, return 1 with the decoded beat once the fill count reaches the code length
  function automatic bit decode_sample(input decoded_t s, input logic first, output decoded_t r);
    int taps;
    int acc_mi;
    int acc_mq;
    int acc_bi;
    int acc_bq;
    bit neg;
    taps = (code_len == 0) ? 1 : (code_len > MAX_BAUD_DEF) ? MAX_BAUD_DEF : int'(code_len);
    if (first) fill_cnt = 0;
    for (int k = MAX_BAUD_DEF - 1; k > 0; k--) begin
      main_i_win[k] = main_i_win[k-1];
      main_q_win[k] = main_q_win[k-1];
      back_i_win[k] = back_i_win[k-1];
      back_q_win[k] = back_q_win[k-1];
    end
    main_i_win[0] = s.main_i;
    main_q_win[0] = s.main_q;
    back_i_win[0] = s.back_i;
    back_q_win[0] = s.back_q;
    if (fill_cnt < MAX_BAUD_DEF) fill_cnt++;
    r = '0;
    if (fill_cnt < taps) return 0;
    acc_mi = 0;
    acc_mq = 0;
    acc_bi = 0;
    acc_bq = 0;
    for (int a = 0; a < taps; a++) begin
      neg = (taps > 1) && code_signs[taps-1-a];
      if (neg) begin
        acc_mi -= main_i_win[a];
        acc_mq -= main_q_win[a];
        acc_bi -= back_i_win[a];
        acc_bq -= back_q_win[a];
      end else begin
        acc_mi += main_i_win[a];
        acc_mq += main_q_win[a];
        acc_bi += back_i_win[a];
        acc_bq += back_q_win[a];
      end
    end
    r.main_i = SAMPLE_W'(acc_mi / taps);
    r.main_q = SAMPLE_W'(acc_mq / taps);
    r.back_i = SAMPLE_W'(acc_bi / taps);
    r.back_q = SAMPLE_W'(acc_bq / taps);
    return 1;
  endfunction

  task automatic add_row(input bit wr, input int len, input int signs, input int rep,
                         input bit first, input decoded_t s, input bit typed,
                         input decoded_t res);
    dir_row_t row;
    row.wr    = wr;
    row.len   = CODE_LEN_W'(len);
    row.signs = SIGNS_W'(signs);
    row.rep   = 5'(rep);
    row.first = first;
    row.smp   = s;
    row.typed = typed;
    row.res   = res;
    dir_rows.push_back(row);
  endtask

  // drain, let the pipeline settle, then write both registers
  task automatic write_code(input logic [CODE_LEN_W-1:0] len, input logic [SIGNS_W-1:0] signs);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CODE_LENGTH;
    cfg_wdata <= CFG_DATA_W'(len);
    @(posedge clk);
    cfg_index <= CFG_CODE_SIGNS;
    cfg_wdata <= signs;
    @(posedge clk);
    cfg_we    <= 1'b0;
    code_len   = len;
    code_signs = signs;
  endtask

  task automatic send_beat(input decoded_t s, input logic first, input bit typed,
                           input decoded_t typed_res);
    decoded_t pred;
    in_valid        <= 1'b1;
    in_main_i       <= s.main_i;
    in_main_q       <= s.main_q;
    in_back_i       <= s.back_i;
    in_back_q       <= s.back_q;
    in_first_sample <= first;
    do @(posedge clk); while (!in_ready);
    if (decode_sample(s, first, pred)) decoded_q.push_back(typed ? typed_res : pred);
    if (tx_idle > 0 && $urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic check_field(input string name, input logic signed [SAMPLE_W-1:0] want,
                             input logic signed [SAMPLE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  // result side: random back-pressure, plus one long hold on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        $error("result beat with nothing expected: %0d %0d %0d %0d", out_main_i_out,
               out_main_q_out, out_back_i_out, out_back_q_out);
        errors++;
      end else begin
        exp_beat = decoded_q.pop_front();
        check_field("main_i_out", exp_beat.main_i, out_main_i_out);
        check_field("main_q_out", exp_beat.main_q, out_main_q_out);
        check_field("back_i_out", exp_beat.back_i, out_back_i_out);
        check_field("back_q_out", exp_beat.back_q, out_back_q_out);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("phase_code_pulse_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    dir_row_t        row;
    decoded_t        s;
    logic [CODE_LEN_W-1:0] len;
    logic [SIGNS_W-1:0]    signs;
    int              items;
    int              taps;
    int              seq_len;
    int              pick;
    bit              held;
    bit              hold_now;
    for (int k = 0; k < MAX_BAUD_DEF; k++) begin
      main_i_win[k] = '0;
      main_q_win[k] = '0;
      back_i_win[k] = '0;
      back_q_win[k] = '0;
    end
    fill_cnt   = 0;
    code_len   = CODE_LEN_W'(1);
    code_signs = '0;
    held       = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset length passes samples straight through
    add_row(0, 1, 'h0000, 1, 1, quad(32767, -32768, -1, 0), 1, quad(32767, -32768, -1, 0));
    add_row(1, 1, 'hFFFF, 1, 0, quad(-32768, 32767, 12345, -12345), 1,
            quad(-32768, 32767, 12345, -12345));
    add_row(1, 0, 'h0001, 1, 0, quad(-1, 1, -2, 2), 1, quad(-1, 1, -2, 2));
    add_row(1, 2, 'h0003, 2, 1, quad(-32768, -32768, -32768, -32768), 1,
            quad(-32768, -32768, -32768, -32768));
    add_row(1, 16, 'hFFFF, 16, 1, quad(-32768, -32768, 32767, 32767), 1,
            quad(-32768, -32768, -32767, -32767));
    add_row(1, 31, 'hA5C3, 1, 0, quad(1000, -2000, 3000, -4000), 0, '0);
    add_row(1, 17, 'h0000, 1, 0, quad(-7, 7, 32767, -32768), 0, '0);
    // shorten the code while the window is still filling
    add_row(1, 4, 'h0005, 2, 1, quad(500, -500, 250, -250), 0, '0);
    add_row(1, 2, 'h0001, 1, 0, quad(-100, 100, 7, -7), 0, '0);

    tx_idle = 25;
    rx_idle = 65;
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.wr) write_code(row.len, row.signs);
      for (int j = 0; j < row.rep; j++) begin
        send_beat(row.smp, row.first && j == 0, row.typed, row.res);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle = (phase == 0) ? 25 : (phase == 1) ? 65 : 0;
      rx_idle = (phase == 0) ? 65 : (phase == 1) ? 25 : 0;
      items = 0;
      while (items < ITEMS_PER_PHASE) begin
        hold_now = (phase == 0 && !held && items >= 100);
        pick = $urandom_range(99);
        if (pick < 6) len = '0;
        else if (pick < 12) len = CODE_LEN_W'($urandom_range(17, 31));
        else if (pick < 20) len = CODE_LEN_W'(16);
        else if (pick < 28) len = CODE_LEN_W'(1);
        else len = CODE_LEN_W'($urandom_range(2, 15));
        // every beat yields a result, so the block backs up during the hold
        if (hold_now) len = CODE_LEN_W'(1);
        pick = $urandom_range(99);
        signs = (pick < 10) ? 16'h0000 : (pick < 20) ? 16'hFFFF : 16'($urandom);
        write_code(len, signs);
        if (hold_now) begin
          hold_req = 1;
          held     = 1;
        end
        taps = (len == 0) ? 1 : (len > MAX_BAUD_DEF) ? MAX_BAUD_DEF : int'(len);
        repeat ($urandom_range(1, 3)) begin
          seq_len = hold_now ? taps + 12 : taps + $urandom_range(0, 12);
          for (int j = 0; j < seq_len; j++) begin
            s.main_i = rand_word();
            s.main_q = rand_word();
            s.back_i = rand_word();
            s.back_q = rand_word();
            send_beat(s, (j == 0 && $urandom_range(9) != 0) || $urandom_range(99) < 3, 0, '0);
            items++;
          end
        end
      end
    end

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("phase_code_pulse_decoder: match");
    end else begin
      $display("phase_code_pulse_decoder: mismatch");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/pcpd_pkg.sv
design/pcpd_div.sv
design/pcpd_dp.sv
design/pcpd_ctrl.sv
design/phase_code_pulse_decoder.sv
bench/phase_code_pulse_decoder_test.sv
